// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the character map of the Base64 stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    // Number of characters a single byte can cause (final byte with full flush).
    localparam int unsigned MAX_CHARS = 4;
    localparam int unsigned IDX_W     = $clog2(MAX_CHARS);

    // Depth of the queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // ASCII code of the pad character '='.
    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // Work handed from the front to the back: the characters of one byte.
    typedef struct packed {
        logic [MAX_CHARS-1:0][6:0] chars;
        logic [IDX_W-1:0]          last_idx;
        logic                      stream_end;
    } job_t;

    // Map a 6-bit symbol to its character of the standard alphabet.
    function automatic logic [6:0] sym_char(input logic [5:0] v);
        logic [6:0] v7;
        logic [6:0] ch;
        v7 = {1'b0, v};
        if (v < 6'd26) begin
            ch = v7 + 7'd65;
        end else if (v < 6'd52) begin
            ch = v7 + 7'd71;
        end else if (v < 6'd62) begin
            ch = v7 - 7'd4;
        end else if (v == 6'd62) begin
            ch = 7'h2B;
        end else begin
            ch = 7'h2F;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
// Front part: accepts bytes, tracks leftover bits and builds character jobs.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          s_stream_end,
    input  wire logic          q_full,
    output logic               q_wr,
    output b64e_pkg::job_t     q_job
);

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_TWO  = 2'd1;
    localparam logic [1:0] PH_FOUR = 2'd2;

    logic [3:0] bits_reg;
    logic [3:0] bits_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_wr    = accept;

    // Build the characters for this byte and the leftover state after it.
    always_comb begin
        q_job.chars      = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
        q_job.stream_end = s_stream_end;
        q_job.last_idx   = '0;
        bits_next        = '0;
        phase_next       = PH_NONE;
        unique case (phase_reg)
            PH_TWO: begin
                q_job.chars[0] = b64e_pkg::sym_char({bits_reg[1:0], s_data_byte[7:4]});
                q_job.chars[1] = b64e_pkg::sym_char({s_data_byte[3:0], 2'b00});
                q_job.last_idx = s_stream_end ? 2'd2 : 2'd0;
                bits_next      = s_data_byte[3:0];
                phase_next     = PH_FOUR;
            end
            PH_FOUR: begin
                q_job.chars[0] = b64e_pkg::sym_char({bits_reg, s_data_byte[7:6]});
                q_job.chars[1] = b64e_pkg::sym_char(s_data_byte[5:0]);
                q_job.last_idx = 2'd1;
            end
            default: begin
                // No bits pending; the unused phase code is treated the same way.
                q_job.chars[0] = b64e_pkg::sym_char(s_data_byte[7:2]);
                q_job.chars[1] = b64e_pkg::sym_char({s_data_byte[1:0], 4'b0000});
                q_job.last_idx = s_stream_end ? 2'd3 : 2'd0;
                bits_next      = {2'b00, s_data_byte[1:0]};
                phase_next     = PH_TWO;
            end
        endcase
        // The final byte returns the encoder to its reset state.
        if (s_stream_end) begin
            bits_next  = '0;
            phase_next = PH_NONE;
        end
    end

    // Leftover state advances on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg  <= '0;
            phase_reg <= PH_NONE;
        end else if (accept) begin
            bits_reg  <= bits_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_queue.sv =====
// Short register queue of character jobs between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire b64e_pkg::job_t wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output b64e_pkg::job_t      rd_data,
    output logic                empty
);

    localparam int unsigned PTR_W = $clog2(b64e_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(b64e_pkg::QUEUE_DEPTH + 1);

    b64e_pkg::job_t    entry_reg [b64e_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full    = (count_reg == CNT_W'(b64e_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(b64e_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(b64e_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
// Back part: plays out the characters of each job through the output register.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    input  wire b64e_pkg::job_t q_job,
    output logic                q_rd,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [6:0]          m_out_char,
    output logic                m_run_last,
    output logic                m_stream_last
);

    b64e_pkg::job_t                job_reg;
    logic                          job_valid_reg;
    logic                          job_valid_next;
    logic [b64e_pkg::IDX_W-1:0]    idx_reg;
    logic [b64e_pkg::IDX_W-1:0]    idx_next;
    logic                          out_valid_reg;
    logic [6:0]                    char_reg;
    logic                          run_last_reg;
    logic                          stream_last_reg;
    logic                          advance;
    logic                          at_last;
    logic                          finishing;

    assign m_valid       = out_valid_reg;
    assign m_out_char    = char_reg;
    assign m_run_last    = run_last_reg;
    assign m_stream_last = stream_last_reg;

    // The output register takes a new character when it is empty or drained.
    assign advance   = !out_valid_reg || m_ready;
    assign at_last   = (idx_reg == job_reg.last_idx);
    assign finishing = job_valid_reg && advance && at_last;
    assign q_rd      = !q_empty && (!job_valid_reg || finishing);

    // Next job and character position.
    always_comb begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (q_rd) begin
            job_valid_next = 1'b1;
            idx_next       = '0;
        end else if (finishing) begin
            job_valid_next = 1'b0;
        end else if (job_valid_reg && advance) begin
            idx_next = idx_reg + b64e_pkg::IDX_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            if (advance) begin
                out_valid_reg <= job_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (q_rd) begin
            job_reg <= q_job;
        end
        if (advance && job_valid_reg) begin
            char_reg        <= job_reg.chars[idx_reg];
            run_last_reg    <= at_last;
            stream_last_reg <= at_last && job_reg.stream_end;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_encoder.sv =====
// Top level of the streaming Base64 encoder.
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 encoder with the standard alphabet and '=' padding. Each
// input transfer carries one raw byte; s_stream_end marks the last byte of a
// stream, after which the encoder flushes the pending bits, pads the output to
// a multiple of four characters and returns to its reset state. Results leave
// one character per transfer, with m_run_last on the last character caused by
// a byte and m_stream_last on the final character of the stream. The output
// side moves one character per cycle while m_ready is high and jobs wait; a
// byte causes one or two characters and a final byte up to four. Bytes are
// accepted every cycle while the two-entry job queue has room. A byte's
// characters pass the job queue, the job register and the output register.
module base64_stream_encoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_stream_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [6:0]       m_out_char,
    output logic             m_run_last,
    output logic             m_stream_last
);

    b64e_pkg::job_t wr_job;
    b64e_pkg::job_t rd_job;
    logic           q_wr;
    logic           q_rd;
    logic           q_full;
    logic           q_empty;

    b64e_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_stream_end (s_stream_end),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_job        (wr_job)
    );

    b64e_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_data (wr_job),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (rd_job),
        .empty   (q_empty)
    );

    b64e_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_job         (rd_job),
        .q_rd          (q_rd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_run_last    (m_run_last),
        .m_stream_last (m_stream_last)
    );

endmodule

`default_nettype wire
